// ===== hdl/mfsc_pkg.sv =====
// Package: shared types and constants of the metadata frame size checker.
`default_nettype none

package mfsc_pkg;

    localparam int DATA_W      = 8;
    localparam int FRAME_W     = 24;
    localparam int LIMIT_W     = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 24;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TAG_COUNT    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_KEY_LENGTH   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALUE_LENGTH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_LENGTH = 8'd3;

    // Reset values of the limits
    localparam logic [LIMIT_W-1:0] RST_MAX_TAG_COUNT    = 16'd32;
    localparam logic [LIMIT_W-1:0] RST_MAX_KEY_LENGTH   = 16'd256;
    localparam logic [LIMIT_W-1:0] RST_MAX_VALUE_LENGTH = 16'd4096;
    localparam logic [FRAME_W-1:0] RST_MAX_FRAME_LENGTH = 24'd65536;

    localparam logic [FRAME_W-1:0] BYTES_SAT = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_KEY   = 2'd1,
        PH_VALUE = 2'd2,
        PH_DATA  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] max_tag_count;
        logic [LIMIT_W-1:0] max_key_length;
        logic [LIMIT_W-1:0] max_value_length;
        logic [FRAME_W-1:0] max_frame_length;
    } limits_t;

    typedef struct packed {
        logic               frame_ok;
        logic [FRAME_W-1:0] frame_bytes;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/mfsc_byte_if.sv =====
// Interface: byte stream channel with last-byte mark.
`default_nettype none

interface mfsc_byte_if;
    logic                       valid;
    logic                       ready;
    logic [mfsc_pkg::DATA_W-1:0] data_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/mfsc_result_if.sv =====
// Interface: frame check result channel.
`default_nettype none

interface mfsc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         frame_ok;
    logic [mfsc_pkg::FRAME_W-1:0] frame_bytes;

    modport source (output valid, output frame_ok, output frame_bytes, input ready);
    modport sink   (input valid, input frame_ok, input frame_bytes, output ready);
endinterface

`default_nettype wire

// ===== hdl/mfsc_cfg_if.sv =====
// Interface: configuration write channel.
`default_nettype none

interface mfsc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mfsc_pkg::CFG_INDEX_W-1:0] index;
    logic [mfsc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/mfsc_cfg_regs.sv =====
// Module: limit registers written over the configuration channel.
`default_nettype none

module mfsc_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mfsc_cfg_if.sink           cfg,
    output mfsc_pkg::limits_t  limits
);
    import mfsc_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;

    assign cfg.ready = 1'b1;
    assign limits    = limits_reg;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_TAG_COUNT:    limits_next.max_tag_count    = cfg.data[LIMIT_W-1:0];
                CFG_MAX_KEY_LENGTH:   limits_next.max_key_length   = cfg.data[LIMIT_W-1:0];
                CFG_MAX_VALUE_LENGTH: limits_next.max_value_length = cfg.data[LIMIT_W-1:0];
                CFG_MAX_FRAME_LENGTH: limits_next.max_frame_length = cfg.data[FRAME_W-1:0];
                default:              limits_next = limits_reg;  // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_tag_count    <= RST_MAX_TAG_COUNT;
            limits_reg.max_key_length   <= RST_MAX_KEY_LENGTH;
            limits_reg.max_value_length <= RST_MAX_VALUE_LENGTH;
            limits_reg.max_frame_length <= RST_MAX_FRAME_LENGTH;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mfsc_frame_core.sv =====
// Module: per-byte frame parser state and the result of the byte in flight.
`default_nettype none

module mfsc_frame_core #(
    parameter int COUNT_FIELD_BYTES  = 2,
    parameter int LENGTH_FIELD_BYTES = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [mfsc_pkg::DATA_W-1:0] data_byte,
    input  wire logic                        last_byte,
    input  wire mfsc_pkg::limits_t           limits,
    output mfsc_pkg::result_t                result
);
    import mfsc_pkg::*;

    localparam int MAXB = (COUNT_FIELD_BYTES > LENGTH_FIELD_BYTES) ?
                          COUNT_FIELD_BYTES : LENGTH_FIELD_BYTES;
    localparam int FW   = 8 * MAXB;
    localparam int IW   = $clog2(MAXB + 1);
    localparam int RW   = FRAME_W + 1;      // required size, holds limit + 1
    localparam int AW   = LIMIT_W + 2;      // 1 + key + value

    phase_t             phase_reg, phase_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [FW-1:0]      shift_reg, shift_next;
    logic [LIMIT_W-1:0] tag_total_reg, tag_total_next;
    logic [LIMIT_W-1:0] tag_index_reg, tag_index_next;
    logic [LIMIT_W-1:0] key_len_reg, key_len_next;
    logic [FRAME_W-1:0] seen_reg, seen_next;
    logic [RW-1:0]      req_reg, req_next;
    logic               fail_reg, fail_next;

    logic               active;
    logic [IW-1:0]      need;
    logic [IW-1:0]      idx_inc;
    logic               field_done;
    logic [FW-1:0]      field_val;
    logic [31:0]        v32;
    logic               count_bad, key_bad, value_bad, field_bad;
    logic               value_take;
    logic [LIMIT_W-1:0] tag_inc;
    logic [AW-1:0]      add_amt;
    logic [RW:0]        req_sum;
    logic [RW-1:0]      req_cap;
    logic               ok;

    // Field assembly and checks
    always_comb
    begin
        active     = !fail_reg && (phase_reg != PH_DATA);
        need       = (phase_reg == PH_COUNT) ? IW'(COUNT_FIELD_BYTES) : IW'(LENGTH_FIELD_BYTES);
        idx_inc    = idx_reg + 1'b1;
        field_done = (idx_inc == need);
        field_val  = (shift_reg << 8) | FW'(data_byte);
        v32        = 32'(field_val);
        count_bad  = (v32 == 32'd0) || (v32 > 32'(limits.max_tag_count));
        key_bad    = (v32 == 32'd0) || (v32 > 32'(limits.max_key_length));
        value_bad  = (v32 > 32'(limits.max_value_length));
        case (phase_reg)
            PH_COUNT: field_bad = count_bad;
            PH_KEY:   field_bad = key_bad;
            PH_VALUE: field_bad = value_bad;
            default:  field_bad = 1'b0;
        endcase
        value_take = active && field_done && (phase_reg == PH_VALUE) && !value_bad;
        tag_inc    = tag_index_reg + 1'b1;
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (active && field_done && !field_bad)
        begin
            case (phase_reg)
                PH_COUNT: phase_next = PH_KEY;
                PH_KEY:   phase_next = PH_VALUE;
                PH_VALUE: phase_next = (tag_inc >= tag_total_reg) ? PH_DATA : PH_KEY;
                default:  phase_next = phase_reg;
            endcase
        end
    end

    // Counters, required size and result
    always_comb
    begin
        idx_next       = idx_reg;
        shift_next     = shift_reg;
        tag_total_next = tag_total_reg;
        tag_index_next = tag_index_reg;
        key_len_next   = key_len_reg;
        req_next       = req_reg;
        fail_next      = fail_reg;
        seen_next      = (seen_reg < BYTES_SAT) ? seen_reg + 1'b1 : seen_reg;

        // Header byte plus, on a good value field, the key and value bytes.
        // One saturating add equals the two in sequence.
        add_amt = AW'(1) + (value_take ? (AW'(key_len_reg) + AW'(v32[LIMIT_W-1:0]))
                                       : AW'(0));
        req_sum = (RW+1)'(req_reg) + (RW+1)'(add_amt);
        req_cap = RW'(limits.max_frame_length) + 1'b1;

        if (active)
        begin
            req_next   = (req_sum > (RW+1)'(req_cap)) ? req_cap : req_sum[RW-1:0];
            idx_next   = field_done ? '0 : idx_inc;
            shift_next = field_done ? '0 : field_val;
            if (field_done)
            begin
                if (field_bad)
                begin
                    fail_next = 1'b1;
                end
                else
                begin
                    case (phase_reg)
                        PH_COUNT:
                        begin
                            tag_total_next = v32[LIMIT_W-1:0];
                            tag_index_next = '0;
                        end
                        PH_KEY:   key_len_next   = v32[LIMIT_W-1:0];
                        PH_VALUE: tag_index_next = tag_inc;
                        default:  tag_index_next = tag_index_reg;
                    endcase
                end
            end
        end

        ok = !fail_next && (phase_next == PH_DATA) &&
             (req_next <= RW'(limits.max_frame_length)) &&
             (RW'(seen_next) >= req_next);
        result.frame_ok    = ok;
        result.frame_bytes = ok ? req_next[FRAME_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COUNT;
            idx_reg       <= '0;
            shift_reg     <= '0;
            tag_total_reg <= '0;
            tag_index_reg <= '0;
            key_len_reg   <= '0;
            seen_reg      <= '0;
            req_reg       <= '0;
            fail_reg      <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg     <= PH_COUNT;
                idx_reg       <= '0;
                shift_reg     <= '0;
                tag_total_reg <= '0;
                tag_index_reg <= '0;
                key_len_reg   <= '0;
                seen_reg      <= '0;
                req_reg       <= '0;
                fail_reg      <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                idx_reg       <= idx_next;
                shift_reg     <= shift_next;
                tag_total_reg <= tag_total_next;
                tag_index_reg <= tag_index_next;
                key_len_reg   <= key_len_next;
                seen_reg      <= seen_next;
                req_reg       <= req_next;
                fail_reg      <= fail_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/metadata_frame_size_checker.sv =====
// Top level: metadata frame size checker, byte stream in, one result per buffer out.
//
//  channel  modport  payload                       transfer when
//  stream   sink     data_byte[7:0], last_byte     valid && ready
//  result   source   frame_ok, frame_bytes[23:0]   valid && ready, once per last byte
//  cfg      sink     index[7:0], data[23:0]        valid && ready (ready tied high)
//
// One byte per cycle sustained. A byte is held in the input register; when the
// parser steps it updates its state from that byte and, on a last byte, also loads
// the result register, which drives the result channel.
// A pending result that is not taken stalls only a following last byte; plain
// bytes keep flowing past it. Reset clears parser state and loads default limits.
`default_nettype none

module metadata_frame_size_checker #(
    parameter int COUNT_FIELD_BYTES  = 2,
    parameter int LENGTH_FIELD_BYTES = 2
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mfsc_byte_if.sink     stream,
    mfsc_result_if.source result,
    mfsc_cfg_if.sink      cfg
);
    import mfsc_pkg::*;

    limits_t             limits;
    result_t             core_res;

    // Input register
    logic                in_valid_reg;
    logic [DATA_W-1:0]   in_data_reg;
    logic                in_last_reg;

    // Result register
    logic                res_valid_reg;
    result_t             res_reg;

    logic                res_free;
    logic                step;

    assign res_free     = !res_valid_reg || result.ready;
    // A last byte needs the result slot; anything else always advances.
    assign step         = in_valid_reg && (!in_last_reg || res_free);
    assign stream.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_data_reg <= stream.data_byte;
            in_last_reg <= stream.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step && in_last_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            res_reg <= core_res;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.frame_ok    = res_reg.frame_ok;
    assign result.frame_bytes = res_reg.frame_bytes;

    mfsc_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    mfsc_frame_core #(
        .COUNT_FIELD_BYTES  (COUNT_FIELD_BYTES),
        .LENGTH_FIELD_BYTES (LENGTH_FIELD_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .limits    (limits),
        .result    (core_res)
    );

endmodule

`default_nettype wire

// ===== hdl/mfsc_checker.sv =====
// Checker: port-level assertions on the frame size checker, bound to the top level.
`default_nettype none

module mfsc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         res_valid,
    input wire logic                         res_ready,
    input wire logic                         res_ok,
    input wire logic [mfsc_pkg::FRAME_W-1:0] res_bytes,
    input wire logic                         cfg_ready
);
    // Held result keeps its payload until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_ok) && $stable(res_bytes))
        else $error("result changed while stalled");

    // Invalid frames report size zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ok |-> res_bytes == '0)
        else $error("invalid result with nonzero size");

    // A good frame holds at least the count field and one key byte
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ok |-> res_bytes != '0)
        else $error("valid result with zero size");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind metadata_frame_size_checker mfsc_checker u_mfsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_ok    (result.frame_ok),
    .res_bytes (result.frame_bytes),
    .cfg_ready (cfg.ready)
);

`default_nettype wire
